// File: rtl/pbp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the pileup base probability block.
package pbp_pkg;

    // Queue and length counter sizing.
    localparam int QUEUE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SKIP_BITS   = 16;

    // Field widths.
    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int PROB_W   = 16;
    localparam int OFFSET_W = 7;
    localparam int CODE_W   = 3;
    localparam int Q_W      = 6;
    localparam int ERR_W    = 17;

    // Request opcodes.
    localparam logic [OPCODE_W-1:0] OP_REF  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BASE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUAL = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_EOL  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_CALL  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

    // Base codes held in the queue.
    localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_T     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_C     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

    // Base column parser modes.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CARET  = 2'd1;
    localparam logic [1:0] MODE_LENGTH = 2'd2;
    localparam logic [1:0] MODE_SKIP   = 2'd3;

    // Characters of interest.
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    // Quality scores at or above this limit have an error term of zero.
    localparam int Q_LIMIT = 52;

    // Reset value of the quality offset register.
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 7'd33;

    // Division by three: floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for x below 2^17.
    localparam int DIV3_SHIFT = 18;
    localparam logic [ERR_W-1:0] DIV3_MUL = 17'd87382;

    // Error term round(65536 * 10^(-q/10)); the last entry serves every q from the limit up.
    localparam logic [ERR_W-1:0] ERR_TABLE [0:Q_LIMIT] = '{
        17'd65536, 17'd52057, 17'd41350, 17'd32846, 17'd26090,
        17'd20724, 17'd16462, 17'd13076, 17'd10387, 17'd8250,
        17'd6554,  17'd5206,  17'd4135,  17'd3285,  17'd2609,
        17'd2072,  17'd1646,  17'd1308,  17'd1039,  17'd825,
        17'd655,   17'd521,   17'd414,   17'd328,   17'd261,
        17'd207,   17'd165,   17'd131,   17'd104,   17'd83,
        17'd66,    17'd52,    17'd41,    17'd33,    17'd26,
        17'd21,    17'd16,    17'd13,    17'd10,    17'd8,
        17'd7,     17'd5,     17'd4,     17'd3,     17'd3,
        17'd2,     17'd2,     17'd1,     17'd1,     17'd1,
        17'd1,     17'd1,     17'd0
    };

    // Work handed from the parser stage to the probability stage.
    typedef struct packed {
        logic                valid;
        logic                pop;
        logic [STATUS_W-1:0] status;
        logic [Q_W-1:0]      q;
    } stage_t;

    // Maps a character to its base code.
    function automatic logic [CODE_W-1:0] base_code(input logic [CHAR_W-1:0] ch);
        logic [CODE_W-1:0] code;
        case (ch)
            8'h41, 8'h61: code = CODE_A;
            8'h54, 8'h74: code = CODE_T;
            8'h47, 8'h67: code = CODE_G;
            8'h43, 8'h63: code = CODE_C;
            default:      code = CODE_OTHER;
        endcase
        return code;
    endfunction

    // Advances a queue pointer with wrap-around.
    function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] ptr);
        logic [ADDR_W-1:0] nxt;
        if (ptr == ADDR_W'(QUEUE_DEPTH - 1))
            nxt = '0;
        else
            nxt = ptr + 1'b1;
        return nxt;
    endfunction

endpackage

// File: rtl/pbp_item_if.sv
`timescale 1ns / 1ps
// Input channel carrying one opcode-tagged character per request.
interface pbp_item_if;
    logic                            valid;
    logic                            ready;
    logic [pbp_pkg::OPCODE_W-1:0]    opcode;
    logic [pbp_pkg::CHAR_W-1:0]      char_byte;

    modport source (output valid, output opcode, output char_byte, input ready);
    modport sink   (input valid, input opcode, input char_byte, output ready);
endinterface

// File: rtl/pbp_result_if.sv
`timescale 1ns / 1ps
// Output channel carrying one status and four base probabilities per request.
interface pbp_result_if;
    logic                            valid;
    logic                            ready;
    logic [pbp_pkg::STATUS_W-1:0]    status;
    logic [pbp_pkg::PROB_W-1:0]      prob_a;
    logic [pbp_pkg::PROB_W-1:0]      prob_t;
    logic [pbp_pkg::PROB_W-1:0]      prob_g;
    logic [pbp_pkg::PROB_W-1:0]      prob_c;

    modport source (output valid, output status, output prob_a, output prob_t,
                    output prob_g, output prob_c, input ready);
    modport sink   (input valid, input status, input prob_a, input prob_t,
                    input prob_g, input prob_c, output ready);
endinterface

// File: rtl/pbp_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel for the quality offset register.
interface pbp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pbp_pkg::OFFSET_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/pbp_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module pbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while no read is requested.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pbp_parser.sv
`timescale 1ns / 1ps
// Base column parser, queue pointers and quality offset register (first stage).
module pbp_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pbp_pkg::OPCODE_W-1:0]   opcode,
    input  logic [pbp_pkg::CHAR_W-1:0]     char_byte,
    input  logic                           cfg_valid,
    input  logic [pbp_pkg::OFFSET_W-1:0]   cfg_data,
    input  logic                           advance,
    output pbp_pkg::stage_t                stage,
    output logic                           ram_we,
    output logic [pbp_pkg::ADDR_W-1:0]     ram_waddr,
    output logic [pbp_pkg::CODE_W-1:0]     ram_wdata,
    output logic                           ram_re,
    output logic [pbp_pkg::ADDR_W-1:0]     ram_raddr
);

    logic [pbp_pkg::OFFSET_W-1:0]   offset_reg;
    logic [pbp_pkg::CODE_W-1:0]     ref_reg, ref_next;
    logic [1:0]                     mode_reg, mode_next;
    logic [pbp_pkg::SKIP_BITS-1:0]  skip_reg, skip_next;
    logic [pbp_pkg::ADDR_W-1:0]     head_reg, head_next;
    logic [pbp_pkg::ADDR_W-1:0]     tail_reg, tail_next;
    logic [pbp_pkg::FILL_W-1:0]     fill_reg, fill_next;
    pbp_pkg::stage_t                stage_reg, stage_next;

    logic                           accept;
    logic                           normal_parse;
    logic                           push_req;
    logic [pbp_pkg::CODE_W-1:0]     push_code;
    logic                           push;
    logic                           drop;
    logic                           pop;
    logic                           empty_q;
    logic                           is_digit;
    logic [3:0]                     digit;
    logic [pbp_pkg::SKIP_BITS+3:0]  len_wide;
    logic [pbp_pkg::SKIP_BITS-1:0]  skip_dec;
    logic [pbp_pkg::CHAR_W:0]       q_diff;
    logic [pbp_pkg::CHAR_W-1:0]     q_raw;
    logic [pbp_pkg::Q_W-1:0]        q_idx;

    // The stage register can take a new request when empty or being drained.
    assign in_ready = !stage_reg.valid || advance;
    assign accept   = in_valid && in_ready;

    // Decimal length accumulation with saturation.
    assign is_digit = (char_byte >= pbp_pkg::CH_ZERO) && (char_byte <= pbp_pkg::CH_NINE);
    assign digit    = 4'(char_byte - pbp_pkg::CH_ZERO);
    assign len_wide = ({4'b0, skip_reg} << 3) + ({4'b0, skip_reg} << 1)
                      + {{pbp_pkg::SKIP_BITS{1'b0}}, digit};
    assign skip_dec = (skip_reg != '0) ? skip_reg - 1'b1 : '0;

    // Quality score, clamped at zero below and at the table limit above.
    assign q_diff = {1'b0, char_byte} - {2'b0, offset_reg};
    assign q_raw  = (char_byte > {1'b0, offset_reg}) ? q_diff[pbp_pkg::CHAR_W-1:0] : '0;
    assign q_idx  = (q_raw >= pbp_pkg::CHAR_W'(pbp_pkg::Q_LIMIT))
                    ? pbp_pkg::Q_W'(pbp_pkg::Q_LIMIT) : q_raw[pbp_pkg::Q_W-1:0];

    // Parser and queue control.
    always_comb
    begin
        ref_next     = ref_reg;
        mode_next    = mode_reg;
        skip_next    = skip_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        normal_parse = 1'b0;
        push_req     = 1'b0;
        push_code    = ref_reg;
        push         = 1'b0;
        drop         = 1'b0;
        pop          = 1'b0;
        empty_q      = 1'b0;

        if (accept)
        begin
            case (opcode)
                pbp_pkg::OP_REF:
                begin
                    ref_next = pbp_pkg::base_code(char_byte);
                end
                pbp_pkg::OP_BASE:
                begin
                    case (mode_reg)
                        pbp_pkg::MODE_CARET:
                        begin
                            mode_next = pbp_pkg::MODE_NORMAL;
                        end
                        pbp_pkg::MODE_LENGTH:
                        begin
                            if (is_digit)
                            begin
                                if (len_wide > {4'b0, {pbp_pkg::SKIP_BITS{1'b1}}})
                                    skip_next = '1;
                                else
                                    skip_next = len_wide[pbp_pkg::SKIP_BITS-1:0];
                            end
                            else if (skip_reg == '0)
                            begin
                                mode_next    = pbp_pkg::MODE_NORMAL;
                                normal_parse = 1'b1;
                            end
                            else
                            begin
                                skip_next = skip_dec;
                                mode_next = (skip_dec == '0) ? pbp_pkg::MODE_NORMAL
                                                             : pbp_pkg::MODE_SKIP;
                            end
                        end
                        pbp_pkg::MODE_SKIP:
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == '0)
                                mode_next = pbp_pkg::MODE_NORMAL;
                        end
                        default:
                        begin
                            normal_parse = 1'b1;
                        end
                    endcase
                end
                pbp_pkg::OP_QUAL:
                begin
                    if (fill_reg == '0)
                        empty_q = 1'b1;
                    else
                        pop = 1'b1;
                end
                default:
                begin
                    head_next = '0;
                    tail_next = '0;
                    fill_next = '0;
                    mode_next = pbp_pkg::MODE_NORMAL;
                    skip_next = '0;
                    ref_next  = pbp_pkg::CODE_OTHER;
                end
            endcase
        end

        // Ordinary base column characters.
        if (normal_parse)
        begin
            if (char_byte == pbp_pkg::CH_DOT || char_byte == pbp_pkg::CH_COMMA)
            begin
                push_req  = 1'b1;
                push_code = ref_reg;
            end
            else if (char_byte == pbp_pkg::CH_DOLLAR)
            begin
                push_req = 1'b0;
            end
            else if (char_byte == pbp_pkg::CH_PLUS || char_byte == pbp_pkg::CH_MINUS)
            begin
                mode_next = pbp_pkg::MODE_LENGTH;
                skip_next = '0;
            end
            else if (char_byte == pbp_pkg::CH_CARET)
            begin
                mode_next = pbp_pkg::MODE_CARET;
            end
            else
            begin
                push_req  = 1'b1;
                push_code = pbp_pkg::base_code(char_byte);
            end
        end

        // Queue push or drop when full.
        if (push_req)
        begin
            if (fill_reg == pbp_pkg::FILL_W'(pbp_pkg::QUEUE_DEPTH))
                drop = 1'b1;
            else
                push = 1'b1;
        end

        if (push)
        begin
            tail_next = pbp_pkg::next_addr(tail_reg);
            fill_next = fill_reg + 1'b1;
        end

        if (pop)
        begin
            head_next = pbp_pkg::next_addr(head_reg);
            fill_next = fill_reg - 1'b1;
        end
    end

    // Work passed on to the probability stage.
    always_comb
    begin
        stage_next        = stage_reg;
        stage_next.valid  = accept && (pop || drop || empty_q);
        stage_next.pop    = pop;
        stage_next.q      = q_idx;
        if (drop)
            stage_next.status = pbp_pkg::ST_DROP;
        else if (empty_q)
            stage_next.status = pbp_pkg::ST_EMPTY;
        else
            stage_next.status = pbp_pkg::ST_CALL;
    end

    // Queue memory access.
    assign ram_we    = push;
    assign ram_waddr = tail_reg;
    assign ram_wdata = push_code;
    assign ram_re    = pop;
    assign ram_raddr = head_reg;

    // Control state and the stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= pbp_pkg::OFFSET_RESET;
            ref_reg    <= pbp_pkg::CODE_OTHER;
            mode_reg   <= pbp_pkg::MODE_NORMAL;
            skip_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            stage_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
                offset_reg <= cfg_data;
            ref_reg  <= ref_next;
            mode_reg <= mode_next;
            skip_reg <= skip_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
            if (in_ready)
                stage_reg.valid <= stage_next.valid;
            if (accept)
            begin
                stage_reg.pop    <= stage_next.pop;
                stage_reg.status <= stage_next.status;
                stage_reg.q      <= stage_next.q;
            end
        end
    end

    assign stage = stage_reg;

endmodule

// File: rtl/pbp_prob.sv
`timescale 1ns / 1ps
// Probability computation and output register (second stage).
module pbp_prob (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pbp_pkg::stage_t               stage,
    input  logic [pbp_pkg::CODE_W-1:0]    code,
    output logic                          advance,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pbp_pkg::STATUS_W-1:0]  status,
    output logic [pbp_pkg::PROB_W-1:0]    prob_a,
    output logic [pbp_pkg::PROB_W-1:0]    prob_t,
    output logic [pbp_pkg::PROB_W-1:0]    prob_g,
    output logic [pbp_pkg::PROB_W-1:0]    prob_c
);

    logic                                 valid_reg;
    logic [pbp_pkg::STATUS_W-1:0]         status_reg;
    logic [pbp_pkg::PROB_W-1:0]           prob_a_reg, prob_a_next;
    logic [pbp_pkg::PROB_W-1:0]           prob_t_reg, prob_t_next;
    logic [pbp_pkg::PROB_W-1:0]           prob_g_reg, prob_g_next;
    logic [pbp_pkg::PROB_W-1:0]           prob_c_reg, prob_c_next;

    logic [pbp_pkg::ERR_W-1:0]            err;
    logic [pbp_pkg::ERR_W-1:0]            called_wide;
    logic [pbp_pkg::PROB_W-1:0]           called;
    logic [pbp_pkg::ERR_W-1:0]            err_plus;
    logic [2*pbp_pkg::ERR_W-1:0]          product;
    logic [pbp_pkg::PROB_W-1:0]           other;
    logic                                 is_call;
    logic                                 emit;

    // The output register is free when empty or being taken this cycle.
    assign advance = !valid_reg || out_ready;

    // Error term and the two probability values.
    assign err         = pbp_pkg::ERR_TABLE[stage.q];
    assign called_wide = pbp_pkg::ERR_W'(65536) - err;
    assign called      = called_wide[pbp_pkg::PROB_W] ? '1 : called_wide[pbp_pkg::PROB_W-1:0];
    assign err_plus    = err + 1'b1;
    assign product     = err_plus * pbp_pkg::DIV3_MUL;
    assign other       = product[pbp_pkg::DIV3_SHIFT +: pbp_pkg::PROB_W];

    // A popped code that is not a base gives no result.
    assign is_call = stage.pop && (code == pbp_pkg::CODE_A || code == pbp_pkg::CODE_T
                                   || code == pbp_pkg::CODE_G || code == pbp_pkg::CODE_C);
    assign emit    = stage.valid && (!stage.pop || is_call);

    // Per-base selection; status results carry zeros.
    always_comb
    begin
        prob_a_next = '0;
        prob_t_next = '0;
        prob_g_next = '0;
        prob_c_next = '0;
        if (is_call)
        begin
            prob_a_next = (code == pbp_pkg::CODE_A) ? called : other;
            prob_t_next = (code == pbp_pkg::CODE_T) ? called : other;
            prob_g_next = (code == pbp_pkg::CODE_G) ? called : other;
            prob_c_next = (code == pbp_pkg::CODE_C) ? called : other;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= emit;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            status_reg <= stage.status;
            prob_a_reg <= prob_a_next;
            prob_t_reg <= prob_t_next;
            prob_g_reg <= prob_g_next;
            prob_c_reg <= prob_c_next;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign prob_a    = prob_a_reg;
    assign prob_t    = prob_t_reg;
    assign prob_g    = prob_g_reg;
    assign prob_c    = prob_c_reg;

endmodule

// File: rtl/pileup_base_probability.sv
`timescale 1ns / 1ps
// A request is registered in the stage register, with its queue memory read,
// and then in the output register: these form the two stages. Throughput: one
// request per cycle unless the output stalls, which holds both stages.
// Reset clears the parser, the queue pointers and the output valid flag and
// sets the quality offset to 33; the queue memory itself is not cleared.
module pileup_base_probability (
    input  logic         clk,
    input  logic         rst_n,
    pbp_item_if.sink     item,
    pbp_result_if.source result,
    pbp_cfg_if.sink      cfg
);

    pbp_pkg::stage_t                stage;
    logic                           advance;
    logic                           ram_we;
    logic [pbp_pkg::ADDR_W-1:0]     ram_waddr;
    logic [pbp_pkg::CODE_W-1:0]     ram_wdata;
    logic                           ram_re;
    logic [pbp_pkg::ADDR_W-1:0]     ram_raddr;
    logic [pbp_pkg::CODE_W-1:0]     ram_rdata;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    // Parser stage.
    pbp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .opcode    (item.opcode),
        .char_byte (item.char_byte),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .advance   (advance),
        .stage     (stage),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    // Base code queue storage.
    pbp_ram #(
        .WIDTH (pbp_pkg::CODE_W),
        .DEPTH (pbp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Probability stage and output register.
    pbp_prob u_prob (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .code      (ram_rdata),
        .advance   (advance),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (result.status),
        .prob_a    (result.prob_a),
        .prob_t    (result.prob_t),
        .prob_g    (result.prob_g),
        .prob_c    (result.prob_c)
    );

endmodule
